// ===== design/largest_square_of_ones_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef LARGEST_SQUARE_OF_ONES_MACROS_SVH
`define LARGEST_SQUARE_OF_ONES_MACROS_SVH

// Same-cycle implication, held off while reset is high.
`define LSQ_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, held off while reset is high.
`define LSQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/lsq_pkg.sv =====
package lsq_pkg;

  // Default number of line store entries.
  localparam int COLS_DEFAULT = 1024;

  // Field widths.
  localparam int CFG_W  = 11;
  localparam int SIDE_W = 11;
  localparam int AREA_W = 21;

  // Saturation value of a square side and the reset row width.
  localparam logic [SIDE_W-1:0] SIDE_MAX   = 11'h7FF;
  localparam logic [CFG_W-1:0]  COLS_RESET = 11'd1024;

  // Flags of the cell that sits in the update stage.
  typedef struct packed {
    logic pixel;
    logic last;
    logic first_row;
    logic col_zero;
    logic row_end;
  } s1_t;

endpackage

// ===== design/lsq_ram.sv =====
module lsq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port; a read in the cycle of a
  // write to the same entry returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/lsq_dp.sv =====
module lsq_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s1_valid,
  input  lsq_pkg::s1_t               s1,
  input  logic [lsq_pkg::SIDE_W-1:0] up,
  output logic [lsq_pkg::SIDE_W-1:0] size,
  output logic                       stall,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [lsq_pkg::AREA_W-1:0] out_area,
  output logic [lsq_pkg::SIDE_W-1:0] out_side
);
  import lsq_pkg::*;

  logic [SIDE_W-1:0]   left_size;
  logic [SIDE_W-1:0]   upper_left_size;
  logic [SIDE_W-1:0]   best_side;
  logic [SIDE_W-1:0]   left;
  logic [SIDE_W-1:0]   upleft;
  logic [SIDE_W-1:0]   min_lu;
  logic [SIDE_W-1:0]   min_all;
  logic [SIDE_W-1:0]   best_next;
  logic [2*SIDE_W-1:0] prod;
  logic                advance;

  // Neighbors outside the image count as zero.
  assign left   = s1.col_zero ? '0 : left_size;
  assign upleft = (s1.col_zero || s1.first_row) ? '0 : upper_left_size;

  // Side of the largest square ending at this cell, saturating.
  always_comb begin
    min_lu  = (up < left) ? up : left;
    min_all = (min_lu < upleft) ? min_lu : upleft;
    if (!s1.pixel) begin
      size = '0;
    end else if (min_all == SIDE_MAX) begin
      size = SIDE_MAX;
    end else begin
      size = min_all + 1'b1;
    end
  end

  assign best_next = (size > best_side) ? size : best_side;
  assign prod      = best_next * best_next;

  // A last cell waits only while the previous result is still not taken.
  assign stall   = s1_valid && s1.last && out_valid && !out_ready;
  assign advance = s1_valid && !stall;

  // Running neighbor sizes, best side and the result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      left_size       <= '0;
      upper_left_size <= '0;
      best_side       <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (advance) begin
        if (s1.last) begin
          out_valid       <= 1'b1;
          best_side       <= '0;
          left_size       <= '0;
          upper_left_size <= '0;
        end else begin
          best_side <= best_next;
          if (s1.row_end) begin
            left_size       <= '0;
            upper_left_size <= '0;
          end else begin
            left_size       <= size;
            upper_left_size <= up;
          end
        end
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (advance && s1.last) begin
      out_side <= best_next;
      out_area <= prod[AREA_W-1:0];
    end
  end

endmodule

// ===== design/largest_square_of_ones.sv =====
// Largest all-ones square over a binary image streamed in raster order, one
// cell per request. It takes one cell every clock cycle unless held off. Each
// cell makes one read and one write of the line store that holds the previous
// row's square sizes, and a cell that reads the entry the cell before it is
// writing gets that value forwarded. The result (side and area) for an image
// is registered as its last cell leaves the update stage. Input is held off
// only while one result waits on the output and the next last cell waits in
// the update stage. The user must set the row width through the configuration
// port while no image is in progress; the block does not enforce this. Zero
// acts as one and values above MAX_COLUMNS act as MAX_COLUMNS. Sides saturate
// at 2047; the area is the low 21 bits of the side squared.
module largest_square_of_ones #(
  parameter int MAX_COLUMNS = lsq_pkg::COLS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,   // [0] cell_req, [7:1] zero
  input  logic                      s_axis_tlast,   // last_cell
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [31:0]               m_axis_tdata,   // [20:0] largest_area, [31:21] largest_side
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [lsq_pkg::CFG_W-1:0] cfg_data
);
  import lsq_pkg::*;

  localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int CMP_W = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;

  logic [CFG_W-1:0]  columns_in_use;
  logic [COL_W-1:0]  column_position;
  logic              in_first_row;
  logic              s1_valid;
  s1_t               s1;
  logic [COL_W-1:0]  s1_col;
  logic              fwd;
  logic [SIDE_W-1:0] fwd_data;
  logic [CMP_W-1:0]  width_force;
  logic [CMP_W-1:0]  col_plus;
  logic              row_end;
  logic              accept;
  logic              advance;
  logic              stall;
  logic [SIDE_W-1:0] rd_data;
  logic [SIDE_W-1:0] up;
  logic [SIDE_W-1:0] size;

  // Row width register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      columns_in_use <= COLS_RESET;
    end else if (cfg_valid) begin
      columns_in_use <= cfg_data;
    end
  end

  // Width in force and end-of-row test.
  always_comb begin
    if (columns_in_use == '0) begin
      width_force = CMP_W'(1);
    end else if (CMP_W'(columns_in_use) > CMP_W'(MAX_COLUMNS)) begin
      width_force = CMP_W'(MAX_COLUMNS);
    end else begin
      width_force = CMP_W'(columns_in_use);
    end
  end

  assign col_plus = CMP_W'(column_position) + CMP_W'(1);
  assign row_end  = col_plus >= width_force;

  assign s_axis_tready = !stall;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign advance       = s1_valid && !stall;

  // Column position and first-row flag move as each cell is accepted.
  always_ff @(posedge clk) begin
    if (rst) begin
      column_position <= '0;
      in_first_row    <= 1'b1;
    end else if (accept) begin
      if (s_axis_tlast) begin
        column_position <= '0;
        in_first_row    <= 1'b1;
      end else if (row_end) begin
        column_position <= '0;
        in_first_row    <= 1'b0;
      end else begin
        column_position <= column_position + 1'b1;
      end
    end
  end

  // Update stage valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  // Update stage payload, with forwarding when the cell ahead writes the
  // entry this cell reads in the same cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1.pixel     <= s_axis_tdata[0];
      s1.last      <= s_axis_tlast;
      s1.first_row <= in_first_row;
      s1.col_zero  <= (column_position == '0);
      s1.row_end   <= row_end;
      s1_col       <= column_position;
      fwd          <= advance && (s1_col == column_position);
      fwd_data     <= size;
    end
  end

  lsq_ram #(
    .WIDTH (SIDE_W),
    .DEPTH (MAX_COLUMNS)
  ) u_line (
    .clk   (clk),
    .we    (advance),
    .waddr (s1_col),
    .wdata (size),
    .re    (accept),
    .raddr (column_position),
    .rdata (rd_data)
  );

  assign up = s1.first_row ? '0 : (fwd ? fwd_data : rd_data);

  lsq_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .s1_valid  (s1_valid),
    .s1        (s1),
    .up        (up),
    .size      (size),
    .stall     (stall),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_area  (m_axis_tdata[20:0]),
    .out_side  (m_axis_tdata[31:21])
  );

endmodule

// ===== design/lsq_checker.sv =====
`include "largest_square_of_ones_macros.svh"

module lsq_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  // The area always matches the side it travels with.
  `LSQ_ASSERT_SAME(a_area_matches, clk, rst, m_axis_tvalid, m_axis_tdata[20:0] == 21'(m_axis_tdata[31:21]) * 21'(m_axis_tdata[31:21]), "area does not match side")

  // A new result must be preceded by an accepted last cell.
  `LSQ_ASSERT_SAME(a_result_after_last, clk, rst, $rose(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2), "result without a last cell")

  // Input is held off only while a result is waiting.
  `LSQ_ASSERT_SAME(a_hold_only_blocked, clk, rst, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input held off without output backpressure")

  // A stalled result keeps its value.
  `LSQ_ASSERT_NEXT(a_result_holds, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule

bind largest_square_of_ones lsq_checker u_chk (.*);
